>>> design/scsu_pkg.sv
// Shared types, command codes and offset tables for the SCSU single-byte decoder.
`timescale 1ns / 1ps

package scsu_pkg;

  localparam int QueueDepth = 4;

  // Single-byte mode command codes
  localparam logic [7:0] CmdQuoteFirst  = 8'h01;
  localparam logic [7:0] CmdQuoteLast   = 8'h08;
  localparam logic [7:0] CmdQuoteUni    = 8'h0E;
  localparam logic [7:0] CmdSelectFirst = 8'h10;
  localparam logic [7:0] CmdSelectLast  = 8'h17;
  localparam logic [7:0] CmdDefineFirst = 8'h18;
  localparam logic [7:0] CmdDefineLast  = 8'h1F;

  // Offset byte ranges of a window definition
  localparam logic [7:0]  OffHangulFirst = 8'h68;
  localparam logic [7:0]  OffReservedLo  = 8'hA8;
  localparam logic [7:0]  OffFixedFirst  = 8'hF9;
  localparam logic [15:0] HangulBase     = 16'hAC00;

  typedef enum logic [2:0] {
    PendNone   = 3'd0,
    PendQuote  = 3'd1,
    PendUHigh  = 3'd2,
    PendULow   = 3'd3,
    PendDefine = 3'd4
  } pend_e;

  // One queue entry: all results caused by one input item
  typedef struct packed {
    logic        char_valid;
    logic [15:0] char_unit;
    logic        term;
  } entry_t;

  function automatic logic [15:0] static_offset(input logic [2:0] idx);
    logic [15:0] r;
    case (idx)
      3'd0: r = 16'h0000;
      3'd1: r = 16'h0080;
      3'd2: r = 16'h0100;
      3'd3: r = 16'h0300;
      3'd4: r = 16'h2000;
      3'd5: r = 16'h2080;
      3'd6: r = 16'h2100;
      3'd7: r = 16'h3000;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] default_offset(input logic [2:0] idx);
    logic [15:0] r;
    case (idx)
      3'd0: r = 16'h0080;
      3'd1: r = 16'h00C0;
      3'd2: r = 16'h0400;
      3'd3: r = 16'h0600;
      3'd4: r = 16'h0900;
      3'd5: r = 16'h3040;
      3'd6: r = 16'h30A0;
      3'd7: r = 16'hFF00;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] fixed_offset(input logic [2:0] idx);
    logic [15:0] r;
    case (idx)
      3'd0: r = 16'h00C0;
      3'd1: r = 16'h0250;
      3'd2: r = 16'h0370;
      3'd3: r = 16'h0530;
      3'd4: r = 16'h3040;
      3'd5: r = 16'h30A0;
      3'd6: r = 16'hFF60;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] offset_from_byte(input logic [7:0] w);
    logic [15:0] shifted;
    logic [15:0] r;
    shifted = {1'b0, w, 7'b0};
    if (w >= OffHangulFirst && w < OffReservedLo) begin
      r = shifted + HangulBase;
    end else if (w >= OffFixedFirst) begin
      r = fixed_offset(w[2:0] - 3'd1);
    end else begin
      r = shifted;
    end
    return r;
  endfunction

endpackage

>>> design/scsu_single_byte_decoder_top.sv
// Top level of the SCSU single-byte mode decoder.
//
// Input channel: one compressed byte per item (code_byte_i) with string_end_i
// marking the last byte of a string; accepted when in_valid_i is high and
// in_stall_o is low. Output channel: one UTF-16 code unit per item
// (code_unit_o) with terminator_o set on the zero that closes each string;
// taken when out_valid_o is high and out_stall_i is low.
// One byte is accepted per cycle while the queue is not full. A byte yields
// zero, one or two results, passed through the queue to the output register.
// One result is output per cycle while out_stall_i is low; a byte with both a
// character and the terminator emits the character first. Window state is
// updated in the accept cycle; a QUEUE_DEPTH-entry queue buffers results
// ahead of the output register, and in_stall_o rises only when it is full.
// Reset clears the queue and output register and loads the default window
// offsets, active window 0 and no pending command. While the receiver stalls,
// the output holds and bytes keep being accepted until the queue fills.
`timescale 1ns / 1ps

module scsu_single_byte_decoder_top #(
  parameter int QUEUE_DEPTH = scsu_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  code_byte_i,
  input  logic        string_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_unit_o,
  output logic        terminator_o
);

  scsu_pkg::entry_t wr_entry;
  scsu_pkg::entry_t rd_entry;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  logic             accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  scsu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .code_byte_i  (code_byte_i),
    .string_end_i (string_end_i),
    .push_o       (push),
    .entry_o      (wr_entry)
  );

  scsu_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .wr_entry_i (wr_entry),
    .pop_i      (pop),
    .rd_entry_o (rd_entry),
    .full_o     (full),
    .empty_o    (empty)
  );

  scsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (rd_entry),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_unit_o  (code_unit_o),
    .terminator_o (terminator_o)
  );

endmodule

>>> design/scsu_front.sv
// Front end: accepts bytes, tracks window state and pending commands, builds queue entries.
`timescale 1ns / 1ps

module scsu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        code_byte_i,
  input  logic              string_end_i,
  output logic              push_o,
  output scsu_pkg::entry_t  entry_o
);

  logic [15:0]     win_q [8];
  logic [15:0]     win_d [8];
  logic [2:0]      act_q, act_d;
  logic [2:0]      pw_q, pw_d;
  logic [7:0]      high_q, high_d;
  scsu_pkg::pend_e pend_q, pend_d;

  logic [2:0]  sel_win;
  logic [15:0] base;
  logic [15:0] sum;
  logic        char_valid;
  logic [15:0] char_unit;
  logic [7:0]  b;

  assign b       = code_byte_i;
  // one read port on the window file: quote reads its named window, else the active one
  assign sel_win = (pend_q == scsu_pkg::PendQuote) ? pw_q : act_q;
  always_comb begin
    if (b[7]) begin
      base = win_q[sel_win];
    end else if (pend_q == scsu_pkg::PendQuote) begin
      base = scsu_pkg::static_offset(pw_q);
    end else begin
      base = 16'h0000;
    end
  end
  assign sum = base + {9'b0, b[6:0]};

  always_comb begin
    win_d      = win_q;
    act_d      = act_q;
    pw_d       = pw_q;
    high_d     = high_q;
    pend_d     = scsu_pkg::PendNone;
    char_valid = 1'b0;
    char_unit  = sum;
    case (pend_q)
      scsu_pkg::PendQuote: begin
        char_valid = 1'b1;
      end
      scsu_pkg::PendUHigh: begin
        high_d = b;
        pend_d = scsu_pkg::PendULow;
      end
      scsu_pkg::PendULow: begin
        char_valid = 1'b1;
        char_unit  = {high_q, b};
      end
      scsu_pkg::PendDefine: begin
        win_d[pw_q] = scsu_pkg::offset_from_byte(b);
        act_d       = pw_q;
      end
      default: begin
        if (b >= scsu_pkg::CmdQuoteFirst && b <= scsu_pkg::CmdQuoteLast) begin
          pw_d   = b[2:0] - 3'd1;
          pend_d = scsu_pkg::PendQuote;
        end else if (b == scsu_pkg::CmdQuoteUni) begin
          pend_d = scsu_pkg::PendUHigh;
        end else if (b >= scsu_pkg::CmdSelectFirst && b <= scsu_pkg::CmdSelectLast) begin
          act_d = b[2:0];
        end else if (b >= scsu_pkg::CmdDefineFirst && b <= scsu_pkg::CmdDefineLast) begin
          pw_d   = b[2:0];
          pend_d = scsu_pkg::PendDefine;
        end else begin
          char_valid = 1'b1;
        end
      end
    endcase
  end

  assign push_o             = accept_i && (char_valid || string_end_i);
  assign entry_o.char_valid = char_valid;
  assign entry_o.char_unit  = char_unit;
  assign entry_o.term       = string_end_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        win_q[i] <= scsu_pkg::default_offset(3'(i));
      end
      act_q  <= 3'd0;
      pw_q   <= 3'd0;
      high_q <= 8'h00;
      pend_q <= scsu_pkg::PendNone;
    end else if (accept_i) begin
      if (string_end_i) begin
        // end of string: windows back to defaults, pending command dropped
        for (int i = 0; i < 8; i++) begin
          win_q[i] <= scsu_pkg::default_offset(3'(i));
        end
        act_q  <= 3'd0;
        pw_q   <= 3'd0;
        high_q <= 8'h00;
        pend_q <= scsu_pkg::PendNone;
      end else begin
        win_q  <= win_d;
        act_q  <= act_d;
        pw_q   <= pw_d;
        high_q <= high_d;
        pend_q <= pend_d;
      end
    end
  end

endmodule

>>> design/scsu_queue.sv
// Small FIFO of result entries between the front end and the output stage.
`timescale 1ns / 1ps

module scsu_queue #(
  parameter int Depth = scsu_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  scsu_pkg::entry_t  wr_entry_i,
  input  logic              pop_i,
  output scsu_pkg::entry_t  rd_entry_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  scsu_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign rd_entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count beyond depth");

endmodule

>>> design/scsu_back.sv
// Output stage: drains queue entries, emitting any character, then any terminator.
`timescale 1ns / 1ps

module scsu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scsu_pkg::entry_t  entry_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       code_unit_o,
  output logic              terminator_o
);

  logic        out_valid_q, out_valid_d;
  logic [15:0] unit_q, unit_d;
  logic        term_q, term_d;
  logic        pend_term_q, pend_term_d;
  logic        load;

  // output register can take a new result when empty or being taken
  assign load  = !out_valid_q || !out_stall_i;
  assign pop_o = load && !pend_term_q && !empty_i;

  always_comb begin
    out_valid_d = out_valid_q;
    unit_d      = unit_q;
    term_d      = term_q;
    pend_term_d = pend_term_q;
    if (load) begin
      if (pend_term_q) begin
        out_valid_d = 1'b1;
        unit_d      = 16'h0000;
        term_d      = 1'b1;
        pend_term_d = 1'b0;
      end else if (!empty_i) begin
        out_valid_d = 1'b1;
        if (entry_i.char_valid) begin
          unit_d      = entry_i.char_unit;
          term_d      = 1'b0;
          pend_term_d = entry_i.term;
        end else begin
          unit_d = 16'h0000;
          term_d = 1'b1;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_term_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_term_q <= pend_term_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q <= unit_d;
    term_q <= term_d;
  end

  assign out_valid_o  = out_valid_q;
  assign code_unit_o  = unit_q;
  assign terminator_o = term_q;

  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && term_q) |-> (unit_q == 16'h0000))
    else $error("terminator carries nonzero unit");
  a_pend_term_behind_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_term_q |-> (out_valid_q && !term_q))
    else $error("held terminator without character ahead of it");
  a_pend_term_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_term_q && out_stall_i) |=> pend_term_q)
    else $error("held terminator lost under stall");

endmodule
